@@ rtl/core/pst_pkg.sv @@
// Shared types, constants and helpers of the playlist shuffle sequencer.
// Used by pst_table, pst_mod, playlist_shuffle_sequencer_unit and the testbench; no dependencies.
`default_nettype none

package pst_pkg;

    // Field and register widths.
    localparam int CMD_W      = 4;
    localparam int VAL_W      = 8;
    localparam int COUNT_W    = 8;
    localparam int SEED_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Play-order table geometry. Song numbers and positions share the address width.
    localparam int ADDR_W      = 8;
    localparam int TABLE_DEPTH = 1 << ADDR_W;

    // Remainder unit: dividend is one bit wider than a position (position + 1).
    localparam int DVD_W     = ADDR_W + 1;
    localparam int MOD_CNT_W = $clog2(DVD_W + 1);

    // Product of a random value and the remaining song count.
    localparam int PROD_W = SEED_W + COUNT_W;

    localparam logic [SEED_W-1:0] LFSR_TAPS = 16'hB400;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_SONG_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_NEXT           = 4'd0,
        CMD_SET_POSITION   = 4'd1,
        CMD_SET_SHUFFLE    = 4'd2,
        CMD_TOGGLE_SHUFFLE = 4'd3,
        CMD_SKIP_BACK      = 4'd4,
        CMD_SET_PAUSED     = 4'd5,
        CMD_SET_DONE       = 4'd6,
        CMD_TAKE_DONE      = 4'd7,
        CMD_INIT_ORDER     = 4'd8
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_NEXT_RD,
        S_MOD,
        S_SH_RD_I,
        S_SH_RD_J,
        S_SH_WR_I,
        S_SH_WR_J,
        S_FINISH
    } state_t;

    // Access request to the play-order table.
    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] wr_data;
        logic              clear;
    } tbl_req_t;

    // Start request to the remainder unit.
    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [COUNT_W-1:0] divisor;
    } mod_req_t;

    // One step of the 16-bit Galois LFSR.
    function automatic logic [SEED_W-1:0] pst_lfsr_step(input logic [SEED_W-1:0] v);
        logic [SEED_W-1:0] s;
        begin
            s = v >> 1;
            if (v[0])
            begin
                s = s ^ LFSR_TAPS;
            end
            return s;
        end
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/pst_table.sv @@
// Play-order table: synchronous single-port-read memory with per-entry valid bits.
// An entry that is not valid reads as its own index. Depends on pst_pkg.
`default_nettype none

module pst_table (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire pst_pkg::tbl_req_t     req,
    output logic [pst_pkg::ADDR_W-1:0] rdata
);
    import pst_pkg::*;

    logic [ADDR_W-1:0]      order_mem_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [ADDR_W-1:0]      rd_data_reg;
    logic [ADDR_W-1:0]      rd_addr_reg;
    logic                   rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            order_mem_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg  <= order_mem_reg[req.rd_addr];
            rd_addr_reg  <= req.rd_addr;
            rd_valid_reg <= valid_reg[req.rd_addr];
        end
    end

    // Clearing all valid bits restores identity order.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.clear)
        begin
            valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : rd_addr_reg;

endmodule

`default_nettype wire

@@ rtl/core/pst_mod.sv @@
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on pst_pkg.
`default_nettype none

module pst_mod (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire pst_pkg::mod_req_t     req,
    output logic                       busy,
    output logic [pst_pkg::ADDR_W-1:0] rem
);
    import pst_pkg::*;

    logic [MOD_CNT_W-1:0] cnt_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [ADDR_W-1:0]    rem_reg;
    logic [COUNT_W-1:0]   dsr_reg;
    logic [DVD_W-1:0]     trial;
    logic                 fits;
    logic [ADDR_W-1:0]    rem_step;

    // The partial remainder stays below the divisor, so one subtract per bit suffices.
    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign fits     = trial >= {1'b0, dsr_reg};
    assign rem_step = fits ? ADDR_W'(trial - {1'b0, dsr_reg}) : trial[ADDR_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (req.start)
        begin
            cnt_reg <= MOD_CNT_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - MOD_CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            dvd_reg <= req.dividend;
            dsr_reg <= req.divisor;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            dvd_reg <= dvd_reg << 1;
            rem_reg <= rem_step;
        end
    end

    assign busy = cnt_reg != '0;
    assign rem  = rem_reg;

endmodule

`default_nettype wire

@@ rtl/core/playlist_shuffle_sequencer_unit.sv @@
// Top level of the playlist shuffle sequencer: command sequencer, state registers,
// output register and assertions. Depends on pst_pkg, pst_table and pst_mod.
`default_nettype none

// The sequencer keeps a 256-entry play-order table of song numbers in a synchronous
// memory, together with the play position and the done, paused and shuffle flags.
// Every command item produces exactly one result item. Items are handled one at a time:
// a command is taken only while the sequencer is idle, but a finished result waits in
// its own output register, so the next command can be taken before the previous result
// is collected. Simple commands pass through the decode and finish states, and the
// sequencer is ready again in the same cycle that their result becomes valid. A next
// command on a nonempty playlist needs one table read; if the stored position lies at
// or beyond the song count, a bit-serial remainder unit then reduces it. Skip back
// uses the remainder unit in that case as well. Shuffle on with two or more songs makes
// song_count - 1 swaps, one at a time through the states read i, read j, write i and
// write j, bounded by the table's single read port. Shuffle off and init order restore
// identity order by clearing the table's per-entry valid bits; there is no clearing
// pass after reset. Configuration may be written at any time the sequencer is idle and
// takes effect with the next command.
module playlist_shuffle_sequencer_unit (
    input  wire                            clk,
    input  wire                            rst_n,
    // Configuration write port.
    input  wire                            cfg_write,
    input  wire [pst_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire [pst_pkg::CFG_DATA_W-1:0]  cfg_data,
    // Command channel.
    input  wire                            in_valid,
    output logic                           in_ready,
    input  wire [pst_pkg::CMD_W-1:0]       command,
    input  wire [pst_pkg::VAL_W-1:0]       value,
    // Result channel.
    output logic                           out_valid,
    input  wire                            out_ready,
    output logic [pst_pkg::ADDR_W-1:0]     song_number,
    output logic [pst_pkg::ADDR_W-1:0]     position,
    output logic                           done_flag,
    output logic                           paused_flag,
    output logic                           shuffle_flag
);
    import pst_pkg::*;

    // Control state.
    state_t              state_reg,  state_next;
    logic [COUNT_W-1:0]  song_count_reg;
    logic [SEED_W-1:0]   seed_reg;
    logic [ADDR_W-1:0]   pos_reg,    pos_next;
    logic                done_reg,   done_next;
    logic                paused_reg, paused_next;
    logic                shuf_reg,   shuf_next;
    logic [SEED_W-1:0]   lfsr_reg,   lfsr_next;
    logic                out_valid_reg, out_valid_next;

    // Payload and working registers.
    cmd_t                cmd_reg;
    logic [VAL_W-1:0]    val_reg;
    logic [ADDR_W-1:0]   song_reg,   song_next;
    logic [ADDR_W-1:0]   i_reg,      i_next;
    logic [ADDR_W-1:0]   j_reg,      j_next;
    logic [PROD_W-1:0]   prod_reg,   prod_next;
    logic [ADDR_W-1:0]   di_reg,     di_next;
    logic [ADDR_W-1:0]   song_out_reg;
    logic [ADDR_W-1:0]   pos_out_reg;
    logic                done_out_reg;
    logic                paused_out_reg;
    logic                shuf_out_reg;

    // Helpers.
    tbl_req_t            tbl_req;
    logic [ADDR_W-1:0]   tbl_rdata;
    mod_req_t            mod_req;
    logic                mod_busy;
    logic [ADDR_W-1:0]   mod_rem;
    logic                in_accept;
    logic                out_free;
    logic                out_load;
    logic                pos_lt_n;
    logic                shuf_on;
    logic [SEED_W-1:0]   lfsr_step;
    logic [DVD_W-1:0]    j_raw;
    logic [ADDR_W-1:0]   j_clamped;
    logic                loop_more;

    // Position two places back, for a position already below the count.
    function automatic logic [ADDR_W-1:0] skip_back(input logic [ADDR_W-1:0] p,
                                                     input logic [COUNT_W-1:0] n);
        logic [ADDR_W-1:0] r;
        begin
            if (n == COUNT_W'(1))
            begin
                r = '0;
            end
            else if (p >= ADDR_W'(2))
            begin
                r = p - ADDR_W'(2);
            end
            else
            begin
                r = p + ADDR_W'(n) - ADDR_W'(2);
            end
            return r;
        end
    endfunction

    pst_table u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (tbl_req),
        .rdata (tbl_rdata)
    );

    pst_mod u_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .busy  (mod_busy),
        .rem   (mod_rem)
    );

    assign in_ready  = state_reg == S_IDLE;
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_load  = (state_reg == S_FINISH) && out_free;

    assign pos_lt_n  = pos_reg < ADDR_W'(song_count_reg);
    assign shuf_on   = (cmd_reg == CMD_SET_SHUFFLE) ? val_reg[0] : !shuf_reg;
    assign lfsr_step = pst_lfsr_step(lfsr_reg);

    // Swap index j = i + ((r * (n - i)) >> 16), kept below the count.
    assign j_raw     = {1'b0, i_reg} + {1'b0, prod_reg[PROD_W-1:SEED_W]};
    assign j_clamped = (j_raw >= {1'b0, song_count_reg}) ? ADDR_W'(song_count_reg - 1'b1)
                                                         : j_raw[ADDR_W-1:0];
    assign loop_more = ({1'b0, i_reg} + DVD_W'(2)) < {1'b0, song_count_reg};

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = S_FINISH;
                if (cmd_reg == CMD_NEXT)
                begin
                    if (song_count_reg != '0)
                    begin
                        state_next = S_NEXT_RD;
                    end
                end
                else if (cmd_reg inside {CMD_SET_SHUFFLE, CMD_TOGGLE_SHUFFLE})
                begin
                    if (shuf_on && (song_count_reg >= COUNT_W'(2)))
                    begin
                        state_next = S_SH_RD_I;
                    end
                end
                else if (cmd_reg == CMD_SKIP_BACK)
                begin
                    if ((song_count_reg != '0) && !pos_lt_n)
                    begin
                        state_next = S_MOD;
                    end
                end
            end
            S_NEXT_RD:
            begin
                state_next = pos_lt_n ? S_FINISH : S_MOD;
            end
            S_MOD:
            begin
                if (!mod_busy)
                begin
                    state_next = S_FINISH;
                end
            end
            S_SH_RD_I:
            begin
                state_next = S_SH_RD_J;
            end
            S_SH_RD_J:
            begin
                state_next = S_SH_WR_I;
            end
            S_SH_WR_I:
            begin
                state_next = S_SH_WR_J;
            end
            S_SH_WR_J:
            begin
                state_next = loop_more ? S_SH_RD_I : S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and output logic.
    always_comb
    begin
        pos_next       = pos_reg;
        done_next      = done_reg;
        paused_next    = paused_reg;
        shuf_next      = shuf_reg;
        lfsr_next      = lfsr_reg;
        song_next      = song_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        prod_next      = prod_reg;
        di_next        = di_reg;
        out_valid_next = out_valid_reg;
        tbl_req        = '0;
        mod_req        = '0;
        mod_req.divisor = song_count_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_DECODE:
            begin
                song_next = '0;
                case (cmd_reg)
                    CMD_NEXT:
                    begin
                        tbl_req.rd_en   = song_count_reg != '0;
                        tbl_req.rd_addr = pos_reg;
                    end
                    CMD_SET_POSITION:
                    begin
                        pos_next = ADDR_W'(val_reg);
                    end
                    CMD_SET_SHUFFLE, CMD_TOGGLE_SHUFFLE:
                    begin
                        shuf_next = shuf_on;
                        pos_next  = '0;
                        done_next = 1'b1;
                        i_next    = '0;
                        // Shuffle off returns the table to identity order.
                        tbl_req.clear = !shuf_on;
                    end
                    CMD_SKIP_BACK:
                    begin
                        done_next = 1'b1;
                        if ((song_count_reg != '0) && pos_lt_n)
                        begin
                            pos_next = skip_back(pos_reg, song_count_reg);
                        end
                        mod_req.start    = (song_count_reg != '0) && !pos_lt_n;
                        mod_req.dividend = {1'b0, pos_reg};
                    end
                    CMD_SET_PAUSED:
                    begin
                        paused_next = val_reg[0];
                    end
                    CMD_SET_DONE:
                    begin
                        done_next = 1'b1;
                    end
                    CMD_INIT_ORDER:
                    begin
                        tbl_req.clear = 1'b1;
                        lfsr_next     = (seed_reg != '0) ? seed_reg : SEED_W'(1);
                    end
                    default:
                    begin
                        // Take done and unused codes change nothing here.
                    end
                endcase
            end
            S_NEXT_RD:
            begin
                song_next = tbl_rdata;
                if (pos_lt_n)
                begin
                    pos_next = (pos_reg == ADDR_W'(song_count_reg - 1'b1))
                               ? '0 : pos_reg + ADDR_W'(1);
                end
                mod_req.start    = !pos_lt_n;
                mod_req.dividend = {1'b0, pos_reg} + DVD_W'(1);
            end
            S_MOD:
            begin
                if (!mod_busy)
                begin
                    pos_next = (cmd_reg == CMD_NEXT) ? mod_rem
                                                     : skip_back(mod_rem, song_count_reg);
                end
            end
            S_SH_RD_I:
            begin
                lfsr_next       = lfsr_step;
                prod_next       = PROD_W'(lfsr_step * (song_count_reg - COUNT_W'(i_reg)));
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = i_reg;
            end
            S_SH_RD_J:
            begin
                di_next         = tbl_rdata;
                j_next          = j_clamped;
                tbl_req.rd_en   = 1'b1;
                tbl_req.rd_addr = j_clamped;
            end
            S_SH_WR_I:
            begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = i_reg;
                tbl_req.wr_data = tbl_rdata;
            end
            S_SH_WR_J:
            begin
                tbl_req.wr_en   = 1'b1;
                tbl_req.wr_addr = j_reg;
                tbl_req.wr_data = di_reg;
                i_next          = i_reg + ADDR_W'(1);
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    // Take done reports the flag first, then clears it.
                    if (cmd_reg == CMD_TAKE_DONE)
                    begin
                        done_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            song_count_reg <= '0;
            seed_reg       <= SEED_W'(1);
            pos_reg        <= '0;
            done_reg       <= 1'b0;
            paused_reg     <= 1'b0;
            shuf_reg       <= 1'b0;
            lfsr_reg       <= SEED_W'(1);
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            done_reg      <= done_next;
            paused_reg    <= paused_next;
            shuf_reg      <= shuf_next;
            lfsr_reg      <= lfsr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_write && (cfg_index == REG_SONG_COUNT))
            begin
                song_count_reg <= cfg_data[COUNT_W-1:0];
            end
            if (cfg_write && (cfg_index == REG_RANDOM_SEED))
            begin
                seed_reg <= cfg_data[SEED_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            cmd_reg <= cmd_t'(command);
            val_reg <= value;
        end
        song_reg <= song_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        prod_reg <= prod_next;
        di_reg   <= di_next;
        if (out_load)
        begin
            song_out_reg   <= song_reg;
            pos_out_reg    <= pos_reg;
            done_out_reg   <= done_reg;
            paused_out_reg <= paused_reg;
            shuf_out_reg   <= shuf_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign song_number  = song_out_reg;
    assign position     = pos_out_reg;
    assign done_flag    = done_out_reg;
    assign paused_flag  = paused_out_reg;
    assign shuffle_flag = shuf_out_reg;

    // The remainder unit only runs while the sequencer waits for it.
    a_mod_owned: assert property (@(posedge clk) disable iff (!rst_n)
        mod_busy |-> (state_reg == S_MOD))
        else $error("remainder unit busy outside its wait state");

    // Every swap writes inside the active part of the table.
    a_swap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SH_WR_J) |-> (j_reg < ADDR_W'(song_count_reg)))
        else $error("shuffle swap index at or beyond the song count");

    // A shuffle pass always runs with the position already rewound.
    a_shuffle_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SH_WR_J) |-> (pos_reg == '0))
        else $error("position not cleared during shuffle");

endmodule

`default_nettype wire

@@ dv/tb_playlist_shuffle_sequencer_unit.sv @@
// Self-checking testbench for playlist_shuffle_sequencer_unit: directed and random command
// items checked against a predictor of the play-order table, position and flags.
// Depends on pst_pkg and the sequencer RTL only.
`timescale 1ns / 1ps

module tb_playlist_shuffle_sequencer_unit;

    import pst_pkg::*;

    // Register indexes past the two real registers; writes to them must be ignored.
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // Command codes the sequencer does not use; they only report the status.
    localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
    localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;

    // Number of counted command items the random part aims for.
    localparam int RANDOM_ITEMS = 700;

    // Cycles to let pass once the last result is in, so the sequencer is surely idle.
    localparam int SETTLE_CYCLES = 16;

    // One result item as the sequencer reports it.
    typedef struct packed {
        logic [ADDR_W-1:0] song;
        logic [ADDR_W-1:0] pos;
        logic              done;
        logic              paused;
        logic              shuffle;
    } playlist_status_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [CMD_W-1:0]      command;
    logic [VAL_W-1:0]      value;
    logic                  out_valid;
    logic                  out_ready;
    logic [ADDR_W-1:0]     song_number;
    logic [ADDR_W-1:0]     position;
    logic                  done_flag;
    logic                  paused_flag;
    logic                  shuffle_flag;

    playlist_shuffle_sequencer_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .song_number  (song_number),
        .position     (position),
        .done_flag    (done_flag),
        .paused_flag  (paused_flag),
        .shuffle_flag (shuffle_flag)
    );

    // Predicted state of the sequencer, updated as each command item is accepted.
    logic [ADDR_W-1:0] song_order [0:TABLE_DEPTH-1];
    logic [ADDR_W-1:0] cur_pos;
    logic              done_bit;
    logic              paused_bit;
    logic              shuffle_bit;
    logic [SEED_W-1:0] rng_state;
    logic [COUNT_W-1:0] cfg_count;
    logic [SEED_W-1:0] cfg_seed;

    // Results predicted but not yet seen on the result channel, oldest first.
    playlist_status_t expected_status_q [$];
    playlist_status_t want_status;

    // Run bookkeeping.
    int failures;
    int results_seen;
    int counted_items;
    int ignored_items;
    int shuffle_passes;
    int phase_count;

    // When set, the matching side runs without any idle cycles.
    logic tx_burst;
    logic rx_burst;
    int   rx_stall_left;

    // The clock runs with a 2 ns period.
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the sequencer hangs; far beyond the slowest correct run.
    initial
    begin
        #20_000_000;
        $display("playlist_shuffle_sequencer_unit test failed");
        $finish;
    end

    // Idle lengths: most are zero or short, a few are long.
    function automatic int pick_gap();
        int roll;
        begin
            roll = $urandom_range(0, 99);
            if (roll < 60)
            begin
                return 0;
            end
            else if (roll < 90)
            begin
                return $urandom_range(1, 3);
            end
            return $urandom_range(10, 40);
        end
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            $display("[%0t] MISMATCH %s: got %0d, predicted %0d", $time, what, got, want);
            failures++;
        end
    endtask

    // Returns the whole play-order table to identity order (entry equals index).
    task automatic restore_identity();
        int k;
        begin
            for (k = 0; k < TABLE_DEPTH; k++)
            begin
                song_order[k[ADDR_W-1:0]] = k[ADDR_W-1:0];
            end
        end
    endtask

    // Shuffle on runs one Fisher-Yates pass over the first song_count entries; shuffle off
    // restores identity order. Either way the position returns to 0 and done is raised.
    task automatic apply_shuffle(input logic turn_on);
        int unsigned n;
        int unsigned i;
        int unsigned j;
        int unsigned r;
        logic [ADDR_W-1:0] held;
        begin
            shuffle_bit = turn_on;
            if (turn_on)
            begin
                n = 32'(cfg_count);
                shuffle_passes++;
                for (i = 0; i + 1 < n; i++)
                begin
                    // Galois LFSR step; the freshly stepped value feeds the swap index.
                    rng_state = (rng_state >> 1) ^ (rng_state[0] ? LFSR_TAPS : '0);
                    r = 32'(rng_state);
                    j = i + ((r * (n - i)) >> 16);
                    if (j >= n)
                    begin
                        j = n - 1;
                    end
                    held = song_order[j[ADDR_W-1:0]];
                    song_order[j[ADDR_W-1:0]] = song_order[i[ADDR_W-1:0]];
                    song_order[i[ADDR_W-1:0]] = held;
                end
            end
            else
            begin
                restore_identity();
            end
            cur_pos = '0;
            done_bit = 1'b1;
        end
    endtask

    // Works out the result of one accepted command item and queues it.
    task automatic predict_command(input logic [CMD_W-1:0] code, input logic [VAL_W-1:0] arg);
        int unsigned n;
        int unsigned p;
        playlist_status_t st;
        begin
            n = 32'(cfg_count);
            st.song = '0;
            case (code)
                CMD_NEXT:
                begin
                    // An empty playlist leaves the position alone and returns song 0.
                    if (n != 0)
                    begin
                        p = 32'(cur_pos);
                        st.song = song_order[p[ADDR_W-1:0]];
                        cur_pos = ADDR_W'((p + 1) % n);
                    end
                end
                CMD_SET_POSITION:
                begin
                    cur_pos = arg;
                end
                CMD_SET_SHUFFLE:
                begin
                    apply_shuffle(arg[0]);
                end
                CMD_TOGGLE_SHUFFLE:
                begin
                    apply_shuffle(!shuffle_bit);
                end
                CMD_SKIP_BACK:
                begin
                    // The position is first folded into range, then moved back two.
                    if (n != 0)
                    begin
                        p = 32'(cur_pos) % n;
                        cur_pos = ADDR_W'((p + 2 * n - 2) % n);
                    end
                    done_bit = 1'b1;
                end
                CMD_SET_PAUSED:
                begin
                    paused_bit = arg[0];
                end
                CMD_SET_DONE:
                begin
                    done_bit = 1'b1;
                end
                CMD_INIT_ORDER:
                begin
                    restore_identity();
                    rng_state = (cfg_seed != '0) ? cfg_seed : SEED_W'(1);
                end
                default:
                begin
                end
            endcase
            st.pos = cur_pos;
            st.done = done_bit;
            st.paused = paused_bit;
            st.shuffle = shuffle_bit;
            // Take done reports the flag as it was, then clears it.
            if (code == CMD_TAKE_DONE)
            begin
                done_bit = 1'b0;
            end
            expected_status_q.push_back(st);
        end
    endtask

    // Sends one command item. Entered and left at a falling edge; valid is only lowered
    // when an idle gap comes before the item, so back-to-back items keep it high.
    task automatic send_command(input logic [CMD_W-1:0] code, input logic [VAL_W-1:0] arg);
        int gap;
        begin
            gap = tx_burst ? 0 : pick_gap();
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            command <= code;
            value <= arg;
            in_valid <= 1'b1;
            @(posedge clk);
            while (!in_ready)
            begin
                @(posedge clk);
            end
            predict_command(code, arg);
            if (code > CMD_INIT_ORDER)
            begin
                ignored_items++;
            end
            else
            begin
                counted_items++;
            end
            @(negedge clk);
        end
    endtask

    // Drops valid and waits until every result has come back and the sequencer has had
    // time to return to idle, so that registers may be written.
    task automatic settle_idle();
        begin
            in_valid <= 1'b0;
            while (expected_status_q.size() != 0)
            begin
                @(negedge clk);
            end
            repeat (SETTLE_CYCLES) @(negedge clk);
        end
    endtask

    // One register write, after which the write enable is lowered again before the task returns.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        begin
            cfg_write <= 1'b1;
            cfg_index <= idx;
            cfg_data <= data;
            if (idx == REG_SONG_COUNT)
            begin
                cfg_count = data[COUNT_W-1:0];
            end
            else if (idx == REG_RANDOM_SEED)
            begin
                cfg_seed = data;
            end
            @(negedge clk);
            cfg_write <= 1'b0;
            @(negedge clk);
        end
    endtask

    // Result side: out_ready is held low for random stretches unless rx_burst is set.
    initial
    begin
        rx_stall_left = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (rx_stall_left > 0)
            begin
                out_ready <= 1'b0;
                rx_stall_left--;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!rx_burst)
                begin
                    rx_stall_left = pick_gap();
                end
            end
        end
    end

    // Every accepted result is compared with the oldest prediction, field by field.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_status_q.size() == 0)
            begin
                report_mismatch("result with nothing predicted, song", int'(song_number), 0);
            end
            else
            begin
                want_status = expected_status_q.pop_front();
                if (song_number !== want_status.song)
                begin
                    report_mismatch("song_number", int'(song_number),
                                    int'(want_status.song));
                end
                if (position !== want_status.pos)
                begin
                    report_mismatch("position", int'(position), int'(want_status.pos));
                end
                if (done_flag !== want_status.done)
                begin
                    report_mismatch("done_flag", int'(done_flag), int'(want_status.done));
                end
                if (paused_flag !== want_status.paused)
                begin
                    report_mismatch("paused_flag", int'(paused_flag),
                                    int'(want_status.paused));
                end
                if (shuffle_flag !== want_status.shuffle)
                begin
                    report_mismatch("shuffle_flag", int'(shuffle_flag),
                                    int'(want_status.shuffle));
                end
            end
        end
    end

    // Song count still zero from reset: next returns song 0 without moving, skip back
    // only raises done, take done reports then clears, shuffle still resets and flags.
    task automatic test_empty_playlist();
        begin
            send_command(CMD_NEXT, 8'd0);
            send_command(CMD_SKIP_BACK, 8'd0);
            send_command(CMD_TAKE_DONE, 8'd0);
            send_command(CMD_TAKE_DONE, 8'd0);
            send_command(CMD_SET_SHUFFLE, 8'd1);
            send_command(CMD_TOGGLE_SHUFFLE, 8'd0);
            settle_idle();
        end
    endtask

    // A single song: a position far past the count is stored, next reads that table entry
    // and wraps to 0, skip back gives 0 and a shuffle leaves the table as it is.
    task automatic test_single_song();
        begin
            write_register(REG_SONG_COUNT, 16'd1);
            send_command(CMD_SET_POSITION, 8'd200);
            send_command(CMD_NEXT, 8'd0);
            send_command(CMD_SKIP_BACK, 8'd0);
            send_command(CMD_TOGGLE_SHUFFLE, 8'd0);
            settle_idle();
        end
    endtask

    // Two songs with a zero seed, which must load 1 into the LFSR instead.
    task automatic test_zero_seed_pair();
        begin
            write_register(REG_RANDOM_SEED, 16'd0);
            write_register(REG_SONG_COUNT, 16'd2);
            send_command(CMD_INIT_ORDER, 8'd0);
            send_command(CMD_SET_SHUFFLE, 8'd1);
            send_command(CMD_NEXT, 8'd0);
            send_command(CMD_NEXT, 8'd0);
            send_command(CMD_SKIP_BACK, 8'd0);
            settle_idle();
        end
    endtask

    // Largest count and seed, spare register indexes, the top position, flag values
    // taken from bit 0 only, an unused command code and a full-length shuffle pass.
    task automatic test_full_playlist();
        begin
            write_register(REG_SONG_COUNT, 16'hFFFF);
            write_register(REG_RANDOM_SEED, 16'hFFFF);
            write_register(REG_SPARE_2, 16'h0000);
            write_register(REG_SPARE_3, 16'hA5A5);
            send_command(CMD_INIT_ORDER, 8'd0);
            send_command(CMD_SET_POSITION, 8'hFF);
            send_command(CMD_NEXT, 8'd0);
            send_command(CMD_SET_PAUSED, 8'hFF);
            send_command(CMD_SET_PAUSED, 8'hFE);
            send_command(CMD_SET_DONE, 8'd0);
            send_command(CMD_UNUSED_HI, 8'hFF);
            send_command(CMD_SET_SHUFFLE, 8'hFF);
            send_command(CMD_NEXT, 8'd0);
            send_command(CMD_SET_SHUFFLE, 8'hFE);
            settle_idle();
        end
    endtask

    // A position argument: mostly inside the playlist, sometimes anywhere.
    function automatic logic [VAL_W-1:0] pick_position();
        begin
            if (cfg_count != 0 && $urandom_range(0, 9) < 7)
            begin
                return VAL_W'($urandom_range(0, cfg_count - 1));
            end
            return VAL_W'($urandom_range(0, 255));
        end
    endfunction

    // Command mix of a playback session: mostly next, with the other buttons spread in.
    task automatic send_session_command();
        int roll;
        logic [VAL_W-1:0] arg;
        begin
            roll = $urandom_range(0, 99);
            arg = VAL_W'($urandom_range(0, 255));
            if (roll < 40)
            begin
                send_command(CMD_NEXT, arg);
            end
            else if (roll < 48)
            begin
                send_command(CMD_SET_POSITION, pick_position());
            end
            else if (roll < 54)
            begin
                send_command(CMD_SET_SHUFFLE, arg);
            end
            else if (roll < 59)
            begin
                send_command(CMD_TOGGLE_SHUFFLE, arg);
            end
            else if (roll < 69)
            begin
                send_command(CMD_SKIP_BACK, arg);
            end
            else if (roll < 76)
            begin
                send_command(CMD_SET_PAUSED, arg);
            end
            else if (roll < 81)
            begin
                send_command(CMD_SET_DONE, arg);
            end
            else if (roll < 89)
            begin
                send_command(CMD_TAKE_DONE, arg);
            end
            else if (roll < 94)
            begin
                send_command(CMD_INIT_ORDER, arg);
            end
            else
            begin
                send_command(CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI)), arg);
            end
        end
    endtask

    // Random phases: each one writes fresh settings while idle, then plays a session.
    // Most sessions start the proper way (init order, then often shuffle) and then mix
    // commands; the rest are raw noise over all sixteen codes.
    task automatic test_random_sessions();
        int roll;
        int len;
        int k;
        logic [COUNT_W-1:0] count_pick;
        logic [SEED_W-1:0]  seed_pick;
        begin
            while (counted_items < RANDOM_ITEMS)
            begin
                settle_idle();
                phase_count++;
                roll = $urandom_range(0, 99);
                if (roll < 10)
                begin
                    count_pick = '0;
                end
                else if (roll < 15)
                begin
                    count_pick = 8'd255;
                end
                else if (roll < 20)
                begin
                    count_pick = 8'd1;
                end
                else if (roll < 60)
                begin
                    count_pick = COUNT_W'($urandom_range(2, 8));
                end
                else if (roll < 85)
                begin
                    count_pick = COUNT_W'($urandom_range(9, 40));
                end
                else
                begin
                    count_pick = COUNT_W'($urandom_range(41, 254));
                end
                roll = $urandom_range(0, 99);
                if (roll < 10)
                begin
                    seed_pick = '0;
                end
                else if (roll < 15)
                begin
                    seed_pick = 16'hFFFF;
                end
                else
                begin
                    seed_pick = SEED_W'($urandom_range(0, 16'hFFFF));
                end
                // Upper data bits of the count write are random and must be dropped.
                write_register(REG_SONG_COUNT, {8'($urandom_range(0, 255)), count_pick});
                write_register(REG_RANDOM_SEED, seed_pick);
                if ($urandom_range(0, 4) == 0)
                begin
                    write_register($urandom_range(0, 1) ? REG_SPARE_3 : REG_SPARE_2,
                                   CFG_DATA_W'($urandom_range(0, 16'hFFFF)));
                end
                tx_burst = ($urandom_range(0, 3) == 0);
                rx_burst = ($urandom_range(0, 3) == 0);
                len = $urandom_range(10, 40);
                if ($urandom_range(0, 9) < 8)
                begin
                    send_command(CMD_INIT_ORDER, VAL_W'($urandom_range(0, 255)));
                    if ($urandom_range(0, 9) < 6)
                    begin
                        send_command(CMD_SET_SHUFFLE, {7'($urandom_range(0, 127)), 1'b1});
                    end
                    for (k = 0; k < len; k++)
                    begin
                        send_session_command();
                    end
                end
                else
                begin
                    for (k = 0; k < len; k++)
                    begin
                        send_command(CMD_W'($urandom_range(0, 15)),
                                     VAL_W'($urandom_range(0, 255)));
                    end
                end
            end
            tx_burst = 1'b0;
            rx_burst = 1'b0;
        end
    endtask

    // Main sequence: reset once, directed cases, random sessions, then drain and judge.
    initial
    begin
        failures = 0;
        results_seen = 0;
        counted_items = 0;
        ignored_items = 0;
        shuffle_passes = 0;
        phase_count = 0;
        tx_burst = 1'b0;
        rx_burst = 1'b0;
        rst_n <= 1'b0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_valid <= 1'b0;
        command <= '0;
        value <= '0;

        // Predicted state after reset, registers included.
        restore_identity();
        cur_pos = '0;
        done_bit = 1'b0;
        paused_bit = 1'b0;
        shuffle_bit = 1'b0;
        rng_state = SEED_W'(1);
        cfg_count = '0;
        cfg_seed = SEED_W'(1);

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_empty_playlist();
        test_single_song();
        test_zero_seed_pair();
        test_full_playlist();
        test_random_sessions();

        // Drain: every predicted result must arrive; the hard stop catches a hang.
        in_valid <= 1'b0;
        while (expected_status_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d commands plus %0d unused codes over %0d setting phases.",
                 counted_items, ignored_items, phase_count);
        $display("Checked %0d results, including %0d shuffle passes.",
                 results_seen, shuffle_passes);
        if (failures == 0)
        begin
            $display("playlist_shuffle_sequencer_unit test passed");
        end
        else
        begin
            $display("playlist_shuffle_sequencer_unit test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/pst_pkg.sv
rtl/core/pst_table.sv
rtl/core/pst_mod.sv
rtl/core/playlist_shuffle_sequencer_unit.sv
dv/tb_playlist_shuffle_sequencer_unit.sv
